/* design/rank_with_ties_core_defines.svh */
// assertion macros for the rank_with_ties_core block
// used by rank_with_ties_core.sv, expects clk and rst in scope
`ifndef RANK_WITH_TIES_CORE_DEFINES_SVH
`define RANK_WITH_TIES_CORE_DEFINES_SVH

// same-cycle implication
`define RWT_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RWT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/rwt_pkg.sv */
// shared types and constants for the rank_with_ties_core block
// no dependencies
`timescale 1ns / 1ps

package rwt_pkg;

  localparam int RANK_W = 8;
  localparam int POS_W  = 6;
  localparam int TIE_W  = 2;

  typedef logic [TIE_W-1:0] tie_t;

  localparam tie_t TIE_AVG   = 2'd0;
  localparam tie_t TIE_MIN   = 2'd1;
  localparam tie_t TIE_DENSE = 2'd2;

  typedef struct packed {
    logic clr;
    logic en;
    logic first;
  } rwt_tally_ctl_t;

endpackage

/* design/rwt_tally.sv */
// compare and count unit: tallies larger, equal and distinct larger keys
// against a reference key and forms the doubled rank; uses rwt_pkg
`timescale 1ns / 1ps

module rwt_tally #(
  parameter int VALUE_BITS = 32,
  parameter int CNT_W      = 7
) (
  input  logic                       clk,
  input  rwt_pkg::rwt_tally_ctl_t    ctl,
  input  logic [VALUE_BITS-1:0]      ref_key,
  input  logic [VALUE_BITS-1:0]      cmp_key,
  input  rwt_pkg::tie_t              method,
  output logic [rwt_pkg::RANK_W-1:0] rank
);

  logic [CNT_W-1:0] greater;
  logic [CNT_W-1:0] equal;
  logic [CNT_W-1:0] distinct;

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      greater  <= '0;
      equal    <= '0;
      distinct <= '0;
    end else if (ctl.en) begin
      if (cmp_key > ref_key) begin
        greater <= greater + CNT_W'(1);
        if (ctl.first) begin
          distinct <= distinct + CNT_W'(1);
        end
      end else if (cmp_key == ref_key) begin
        equal <= equal + CNT_W'(1);
      end
    end
  end

  logic [rwt_pkg::RANK_W-1:0] g_r;
  logic [rwt_pkg::RANK_W-1:0] e_r;
  logic [rwt_pkg::RANK_W-1:0] d_r;

  assign g_r = rwt_pkg::RANK_W'(greater);
  assign e_r = rwt_pkg::RANK_W'(equal);
  assign d_r = rwt_pkg::RANK_W'(distinct);

  always_comb begin
    case (method)
      rwt_pkg::TIE_MIN:   rank = (g_r + rwt_pkg::RANK_W'(1)) << 1;
      rwt_pkg::TIE_DENSE: rank = (d_r + rwt_pkg::RANK_W'(1)) << 1;
      default:            rank = g_r + g_r + e_r + rwt_pkg::RANK_W'(1);
    endcase
  end

endmodule

/* design/rank_with_ties_core.sv */
// rank_with_ties_core: stores a set of signed values, ranks them with ties
// uses rwt_pkg, rwt_tally and rank_with_ties_core_defines.svh
//
//   channel   handshake                  payload
//   sample    sample_valid/sample_stall  sample_value, is_final
//   rank      rank_valid/rank_stall      position, rank_doubled, dropped_items, end_of_run
//   config    cfg_wr_en                  cfg_wr_data (tie_method)
//
// loading takes one cycle per word; the final word of a set of n starts ranking
// ranking: a duplicate pass marks repeated keys, a rank pass tallies each word against
// the set, then result words go out; both passes share the single value memory read port
// sample_stall is high from the final word until the last result word is taken
// rank_stall holds the current result word; reset clears count, flags and method
`timescale 1ns / 1ps
`include "rank_with_ties_core_defines.svh"

module rank_with_ties_core #(
  parameter int MAX_ITEMS  = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  rwt_pkg::tie_t              cfg_wr_data,
  input  logic signed [31:0]         sample_value,
  input  logic                       is_final,
  input  logic                       sample_valid,
  output logic                       sample_stall,
  output logic [rwt_pkg::POS_W-1:0]  position,
  output logic [rwt_pkg::RANK_W-1:0] rank_doubled,
  output logic                       dropped_items,
  output logic                       end_of_run,
  output logic                       rank_valid,
  input  logic                       rank_stall
);

  localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);

  typedef enum logic [10:0] {
    S_LOAD  = 11'b00000000001,
    S_FRD   = 11'b00000000010,
    S_FLAT  = 11'b00000000100,
    S_FSCAN = 11'b00000001000,
    S_RRD   = 11'b00000010000,
    S_RLAT  = 11'b00000100000,
    S_RSCAN = 11'b00001000000,
    S_RWR   = 11'b00010000000,
    S_ORD   = 11'b00100000000,
    S_OUT   = 11'b01000000000,
    S_IDLE2 = 11'b10000000000
  } state_t;

  state_t                     state;
  rwt_pkg::tie_t              method;
  logic [CW-1:0]              count;
  logic                       ovf;
  logic [CW-1:0]              oi;
  logic [CW-1:0]              sc;
  logic                       pend;
  logic [VALUE_BITS-1:0]      ref_key;
  logic [VALUE_BITS:0]        val_rd;
  logic [rwt_pkg::RANK_W-1:0] rank_rd;
  logic [rwt_pkg::RANK_W-1:0] tally_rank;

  // top bit of each entry marks the first occurrence of its key
  logic [VALUE_BITS:0]        value_mem [MAX_ITEMS];
  logic [rwt_pkg::RANK_W-1:0] rank_mem  [MAX_ITEMS];

  // order-preserving key
  logic signed [63:0]    sample_ext;
  logic [VALUE_BITS-1:0] key;
  assign sample_ext = 64'(sample_value);
  assign key = {~sample_ext[VALUE_BITS-1], sample_ext[VALUE_BITS-2:0]};

  logic          accept;
  logic          store_ok;
  logic [CW-1:0] n_after;
  assign accept   = sample_valid && !sample_stall;
  assign store_ok = count < CW'(MAX_ITEMS);
  assign n_after  = store_ok ? count + CW'(1) : count;

  logic          scanning;
  logic [CW-1:0] limit;
  logic          issue;
  logic          scan_done;
  logic [IW-1:0] rd_addr;
  logic          dup_hit;
  assign scanning  = (state == S_FSCAN) || (state == S_RSCAN);
  assign limit     = (state == S_FSCAN) ? oi : count;
  assign issue     = scanning && (sc < limit);
  assign scan_done = !issue && !pend;
  assign rd_addr   = scanning ? sc[IW-1:0] : oi[IW-1:0];
  assign dup_hit   = (state == S_FSCAN) && pend && (val_rd[VALUE_BITS-1:0] == ref_key);

  always_ff @(posedge clk) begin
    if (accept && store_ok) begin
      value_mem[count[IW-1:0]] <= {1'b1, key};
    end else if (dup_hit) begin
      value_mem[oi[IW-1:0]] <= {1'b0, ref_key};
    end
    val_rd <= value_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state == S_RWR) begin
      rank_mem[oi[IW-1:0]] <= tally_rank;
    end
    if (state == S_ORD) begin
      rank_rd <= rank_mem[oi[IW-1:0]];
    end
  end

  rwt_pkg::rwt_tally_ctl_t tally_ctl;
  assign tally_ctl.clr   = (state == S_RLAT);
  assign tally_ctl.en    = (state == S_RSCAN) && pend;
  assign tally_ctl.first = val_rd[VALUE_BITS];

  rwt_tally #(
    .VALUE_BITS (VALUE_BITS),
    .CNT_W      (CW)
  ) u_tally (
    .clk     (clk),
    .ctl     (tally_ctl),
    .ref_key (ref_key),
    .cmp_key (val_rd[VALUE_BITS-1:0]),
    .method  (method),
    .rank    (tally_rank)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      method <= rwt_pkg::TIE_AVG;
    end else if (cfg_wr_en) begin
      method <= cfg_wr_data;
    end
  end

  // scan pipeline and working registers
  always_ff @(posedge clk) begin
    if (scanning) begin
      pend <= issue;
      sc   <= sc + CW'(issue);
    end else begin
      pend <= 1'b0;
      sc   <= '0;
    end
    if ((state == S_FLAT) || (state == S_RLAT)) begin
      ref_key <= val_rd[VALUE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      ovf   <= 1'b0;
      oi    <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            count <= n_after;
            if (!store_ok) begin
              ovf <= 1'b1;
            end
            if (is_final) begin
              if (n_after > CW'(1)) begin
                state <= S_FRD;
                oi    <= CW'(1);
              end else begin
                state <= S_RRD;
                oi    <= '0;
              end
            end
          end
        end
        S_FRD:  state <= S_FLAT;
        S_FLAT: state <= S_FSCAN;
        S_FSCAN: begin
          if (scan_done) begin
            if (oi + CW'(1) == count) begin
              state <= S_RRD;
              oi    <= '0;
            end else begin
              state <= S_FRD;
              oi    <= oi + CW'(1);
            end
          end
        end
        S_RRD:  state <= S_RLAT;
        S_RLAT: state <= S_RSCAN;
        S_RSCAN: begin
          if (scan_done) begin
            state <= S_RWR;
          end
        end
        S_RWR: begin
          if (oi + CW'(1) == count) begin
            state <= S_ORD;
            oi    <= '0;
          end else begin
            state <= S_RRD;
            oi    <= oi + CW'(1);
          end
        end
        S_ORD: state <= S_OUT;
        S_OUT: begin
          if (!rank_stall) begin
            if (end_of_run) begin
              state <= S_LOAD;
              count <= '0;
              ovf   <= 1'b0;
            end else begin
              state <= S_ORD;
              oi    <= oi + CW'(1);
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assign sample_stall  = (state != S_LOAD);
  assign rank_valid    = (state == S_OUT);
  assign position      = rwt_pkg::POS_W'(oi);
  assign rank_doubled  = rank_rd;
  assign dropped_items = ovf;
  assign end_of_run    = (oi + CW'(1) == count);

  logic                       rank_take;
  logic [rwt_pkg::RANK_W-1:0] rank_cap;
  logic                       rank_ok;
  logic                       load_clean;
  assign rank_take  = rank_valid && !rank_stall;
  assign rank_cap   = rwt_pkg::RANK_W'({count, 1'b0});
  assign rank_ok    = (rank_doubled >= rwt_pkg::RANK_W'(2)) && (rank_doubled <= rank_cap);
  assign load_clean = (count == '0) && !dropped_items && !sample_stall;

  `RWT_ASSERT(a_emit_nonempty, rank_valid, count != '0, "result word with empty set")
  `RWT_ASSERT(a_no_load_in_emit, !sample_stall, !rank_valid, "sample taken while emitting")
  `RWT_ASSERT(a_rank_range, rank_valid, rank_ok, "rank out of range")
  `RWT_ASSERT_NEXT(a_run_closes, rank_take && end_of_run, load_clean, "set not closed")
  `RWT_ASSERT(a_count_cap, 1'b1, count <= CW'(MAX_ITEMS), "stored count beyond capacity")

endmodule

/* tb/tb_top.sv */
// self-checking testbench for rank_with_ties_core: directed sets, then random sets under all
// tie methods, overflow sets, random sample gaps and random rank stalls; depends on rwt_pkg
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_ITEMS = 64;
  localparam rwt_pkg::tie_t TIE_SPARE = 2'd3;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

  typedef struct {
    logic [rwt_pkg::POS_W-1:0]  pos;
    logic [rwt_pkg::RANK_W-1:0] rank;
    logic                       drop;
    logic                       last;
  } rank_word_t;

  class rank_scoreboard;
    rwt_pkg::tie_t method;
    logic signed [31:0] held[$];
    bit overflow;
    rank_word_t expected[$];
    int errors;
    int words_checked;
    int sets_done;
    int overflow_sets;

    function new();
      method = rwt_pkg::TIE_AVG;
      overflow = 0;
      errors = 0;
      words_checked = 0;
      sets_done = 0;
      overflow_sets = 0;
    endfunction

    // store the word and, on the final one, rank the whole set
    function void note_sample(logic signed [31:0] v, logic fin);
      int greater, equal, distinct, r;
      bit first;
      rank_word_t w;
      if (held.size() < MAX_ITEMS) held.push_back(v);
      else overflow = 1;
      if (!fin) return;
      for (int i = 0; i < held.size(); i++) begin
        greater = 0;
        equal = 0;
        distinct = 0;
        for (int j = 0; j < held.size(); j++) begin
          if (held[j] > held[i]) begin
            greater++;
            first = 1;
            for (int k = 0; k < j; k++)
              if (held[k] == held[j]) first = 0;
            if (first) distinct++;
          end else if (held[j] == held[i]) begin
            equal++;
          end
        end
        case (method)
          rwt_pkg::TIE_MIN:   r = 2 * (greater + 1);
          rwt_pkg::TIE_DENSE: r = 2 * (distinct + 1);
          default:            r = 2 * greater + equal + 1;
        endcase
        w.pos = i[rwt_pkg::POS_W-1:0];
        w.rank = r[rwt_pkg::RANK_W-1:0];
        w.drop = overflow;
        w.last = (i == held.size() - 1);
        expected.push_back(w);
      end
      sets_done++;
      if (overflow) overflow_sets++;
      held.delete();
      overflow = 0;
    endfunction

    function void check_rank(rank_word_t got);
      rank_word_t exp;
      if (expected.size() == 0) begin
        errors++;
        $error("unexpected rank word at position %0d", got.pos);
        return;
      end
      exp = expected.pop_front();
      words_checked++;
      if (got.pos !== exp.pos) begin
        errors++;
        $error("position: expected %0d, got %0d", exp.pos, got.pos);
      end
      if (got.rank !== exp.rank) begin
        errors++;
        $error("rank_doubled: expected %0d, got %0d", exp.rank, got.rank);
      end
      if (got.drop !== exp.drop) begin
        errors++;
        $error("dropped_items: expected %0b, got %0b", exp.drop, got.drop);
      end
      if (got.last !== exp.last) begin
        errors++;
        $error("end_of_run: expected %0b, got %0b", exp.last, got.last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  rwt_pkg::tie_t cfg_wr_data = rwt_pkg::TIE_AVG;
  logic signed [31:0] sample_value = '0;
  logic is_final = 1'b0;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic [rwt_pkg::POS_W-1:0] position;
  logic [rwt_pkg::RANK_W-1:0] rank_doubled;
  logic dropped_items;
  logic end_of_run;
  logic rank_valid;
  logic rank_stall = 1'b0;

  bit steady = 0;
  rank_scoreboard sb;

  rank_with_ties_core #(
    .MAX_ITEMS(MAX_ITEMS),
    .VALUE_BITS(32)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .sample_value(sample_value),
    .is_final(is_final),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .position(position),
    .rank_doubled(rank_doubled),
    .dropped_items(dropped_items),
    .end_of_run(end_of_run),
    .rank_valid(rank_valid),
    .rank_stall(rank_stall)
  );

  always #5 clk = ~clk;

  // result side: check accepted words, stall at random
  always @(posedge clk) begin
    rank_word_t got;
    if (!rst && rank_valid && !rank_stall) begin
      got.pos = position;
      got.rank = rank_doubled;
      got.drop = dropped_items;
      got.last = end_of_run;
      sb.check_rank(got);
    end
    rank_stall <= !steady && ($urandom_range(0, 99) < 21);
  end

  task automatic send_sample(input logic signed [31:0] v, input logic fin);
    while (!steady && $urandom_range(0, 99) < 21) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_value <= v;
    is_final <= fin;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    sb.note_sample(v, fin);
  endtask

  task automatic write_tie_method(input rwt_pkg::tie_t m);
    sample_valid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.method = m;
  endtask

  // mode 0: narrow range, heavy ties; mode 1: full range; else: small pool of values
  task automatic run_set(input int len, input int mode);
    logic signed [31:0] pool[4];
    logic signed [31:0] v;
    for (int k = 0; k < 4; k++) begin
      if ($urandom_range(0, 3) == 0) pool[k] = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
      else pool[k] = $urandom();
    end
    for (int n = 0; n < len; n++) begin
      case (mode)
        0:       v = $signed($urandom_range(0, 6)) - 3;
        1:       v = $urandom();
        default: v = pool[$urandom_range(0, 3)];
      endcase
      send_sample(v, n == len - 1);
    end
  endtask

  task automatic run_phase(input rwt_pkg::tie_t m, input int budget, input int long_len);
    int count;
    write_tie_method(m);
    count = long_len;
    if (long_len > 0) run_set(long_len, $urandom_range(0, 2));
    while (count < budget) begin
      int len;
      len = $urandom_range(1, 12);
      run_set(len, $urandom_range(0, 2));
      count += len;
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes and ties under the reset method
    send_sample(VAL_MAX, 1'b0);
    send_sample(VAL_MIN, 1'b0);
    send_sample(32'sd0, 1'b0);
    send_sample(-32'sd1, 1'b0);
    send_sample(32'sd1, 1'b0);
    send_sample(VAL_MAX, 1'b0);
    send_sample(VAL_MIN, 1'b1);
    send_sample(32'sd5, 1'b1);

    write_tie_method(rwt_pkg::TIE_MIN);
    send_sample(32'sd3, 1'b0);
    send_sample(32'sd3, 1'b0);
    send_sample(-32'sd2, 1'b0);
    send_sample(32'sd7, 1'b0);
    send_sample(32'sd3, 1'b1);

    write_tie_method(rwt_pkg::TIE_DENSE);
    send_sample(32'sd3, 1'b0);
    send_sample(32'sd3, 1'b0);
    send_sample(-32'sd2, 1'b0);
    send_sample(32'sd7, 1'b0);
    send_sample(32'sd3, 1'b1);

    // unused method code ranks as average
    write_tie_method(TIE_SPARE);
    send_sample(-32'sd1, 1'b0);
    send_sample(-32'sd1, 1'b0);
    send_sample(VAL_MAX, 1'b0);
    send_sample(VAL_MIN, 1'b1);

    // random sets; full store, then overflow sets that drop the words beyond MAX_ITEMS
    run_phase(rwt_pkg::TIE_MIN, 80, MAX_ITEMS);
    steady = 1;
    run_phase(rwt_pkg::TIE_DENSE, 80, 0);
    steady = 0;
    run_phase(rwt_pkg::TIE_AVG, 80, MAX_ITEMS + 3);
    run_phase(TIE_SPARE, 80, MAX_ITEMS + 1);

    sample_valid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("ranked %0d sets (%0d with dropped words), %0d rank words checked",
             sb.sets_done, sb.overflow_sets, sb.words_checked);
    $display("tie methods covered: average, minimum, dense and the unused code");
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout waiting for the block");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
